// File: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MGT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MGT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/mgt_pkg.sv
package mgt_pkg;

  // Window sizes and the widths that follow from them.
  localparam int MOTION_DEPTH = 16;
  localparam int BAND_DEPTH   = 64;
  localparam int MPOS_W  = (MOTION_DEPTH > 1) ? $clog2(MOTION_DEPTH) : 1;
  localparam int MFILL_W = $clog2(MOTION_DEPTH + 1);
  localparam int BPOS_W  = $clog2(BAND_DEPTH);
  localparam int BFILL_W = $clog2(BAND_DEPTH + 1);
  localparam int WALK_W  = (MFILL_W > BFILL_W) ? MFILL_W : BFILL_W;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_RMS_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_ALPHA_Q8   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALM_WINDOWS_NEEDED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_PERCENT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_PERCENT        = 3'd4;

  // Trend codes.
  localparam logic [1:0] TREND_UNKNOWN = 2'd0;
  localparam logic [1:0] TREND_STABLE  = 2'd1;
  localparam logic [1:0] TREND_RISING  = 2'd2;
  localparam logic [1:0] TREND_FALLING = 2'd3;

  typedef enum logic [1:0] {
    KIND_ACCEL  = 2'd0,
    KIND_SENSOR = 2'd1,
    KIND_EVENT  = 2'd2,
    KIND_EVAL   = 2'd3
  } kind_e;

  typedef enum logic {
    ITER_DIV  = 1'b0,
    ITER_SQRT = 1'b1
  } iter_mode_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        sensor_mv;
  } in_t;

  typedef struct packed {
    logic [15:0] motion_rms;
    logic        moving;
    logic [15:0] event_count;
    logic [15:0] mix_energy;
    logic [15:0] ema_energy;
    logic [1:0]  trend;
    logic        trend_valid;
  } out_t;

  typedef struct packed {
    logic [15:0] motion_rms_limit;
    logic [8:0]  baseline_alpha_q8;
    logic [7:0]  calm_windows_needed;
    logic [15:0] rise_percent;
    logic [15:0] fall_percent;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        sensor_mv;
  } qent_t;

  typedef struct packed {
    logic        start;
    iter_mode_e  mode;
    logic [31:0] a;
    logic [15:0] b;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } iter_resp_t;

  typedef struct packed {
    logic pop;
    logic res_load;
  } bk_stat_t;

endpackage

// File: rtl/core/motion_gated_energy_trend.sv
// An evaluate with full windows makes three window walks at one entry per cycle, up to four
// 32-step divisions and one 16-step root in the shared iterative unit.
// Throughput: one request in the back at a time; a two-entry queue takes requests meanwhile.
// Reset: asynchronous, active low; clears counters, filters, baseline and config to defaults.
// Window stores need no clearing: only filled entries are read.
module motion_gated_energy_trend (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mgt_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mgt_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [mgt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mgt_pkg::CFG_W-1:0]           cfg_data_i
);
  import mgt_pkg::*;
  `include "assert_macros.svh"

  cfg_t     cfg_q, cfg_d;
  logic     push, q_full, q_empty;
  qent_t    entry, head;
  bk_stat_t stat;

  // Configuration registers; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MOTION_RMS_LIMIT:    cfg_d.motion_rms_limit    = cfg_data_i;
        CFG_BASELINE_ALPHA_Q8:   cfg_d.baseline_alpha_q8   = cfg_data_i[8:0];
        CFG_CALM_WINDOWS_NEEDED: cfg_d.calm_windows_needed = cfg_data_i[7:0];
        CFG_RISE_PERCENT:        cfg_d.rise_percent        = cfg_data_i;
        CFG_FALL_PERCENT:        cfg_d.fall_percent        = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_rms_limit    <= 16'd100;
      cfg_q.baseline_alpha_q8   <= 9'd16;
      cfg_q.calm_windows_needed <= 8'd3;
      cfg_q.rise_percent        <= 16'd20;
      cfg_q.fall_percent        <= 16'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mgt_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  mgt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (stat.pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  mgt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head),
    .cfg_i       (cfg_q),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Queue and result-register consistency.
  `MGT_ASSERT_SAME(a_pop_nonempty, clk_i, rst_ni, stat.pop, !q_empty)
  `MGT_ASSERT_SAME(a_push_room, clk_i, rst_ni, push, !q_full)
  `MGT_ASSERT_SAME(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(stat.res_load))
  `MGT_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, stat.res_load, out_valid_o)

endmodule

// File: rtl/core/mgt_ram.sv
module mgt_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mgt_iter.sv
module mgt_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mgt_pkg::iter_req_t  req_i,
  output mgt_pkg::iter_resp_t resp_o
);
  import mgt_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  iter_mode_e  mode_q, mode_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] x_q, x_d;
  logic [31:0] r_q, r_d;
  logic [31:0] bit_q, bit_d;
  logic [15:0] d_q, d_d;
  logic [16:0] rsh;
  logic        ge;
  logic [31:0] trial;

  // One quotient bit or one root bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    d_d    = d_q;
    rsh    = {r_q[15:0], x_q[31]};
    ge     = (rsh >= {1'b0, d_q});
    trial  = r_q + bit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      x_d    = req_i.a;
      r_d    = '0;
      bit_d  = 32'h4000_0000;
      d_d    = req_i.b;
      cnt_d  = (req_i.mode == ITER_DIV) ? 5'd31 : 5'd15;
    end else if (busy_q) begin
      if (mode_q == ITER_DIV) begin
        x_d = {x_q[30:0], ge};
        r_d = ge ? 32'(rsh - {1'b0, d_q}) : 32'(rsh);
      end else begin
        if (x_q >= trial) begin
          x_d = x_q - trial;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= ITER_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    d_q   <= d_d;
  end

  assign resp_o.done   = done_q;
  assign resp_o.result = (mode_q == ITER_DIV) ? x_q : r_q;

endmodule

// File: rtl/core/mgt_fifo.sv
module mgt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mgt_pkg::qent_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output mgt_pkg::qent_t head_o,
  output logic           empty_o
);
  import mgt_pkg::*;

  qent_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/core/mgt_front.sv
module mgt_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mgt_pkg::in_t   in_data_i,
  input  logic           q_full_i,
  output logic           push_o,
  output mgt_pkg::qent_t entry_o
);
  import mgt_pkg::*;

  // A request is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the request and keep only the fields the back needs.
  always_comb begin
    entry_o.accel_x   = in_data_i.accel_x;
    entry_o.accel_y   = in_data_i.accel_y;
    entry_o.accel_z   = in_data_i.accel_z;
    entry_o.sensor_mv = in_data_i.sensor_mv;
    case (in_data_i.operation)
      KIND_ACCEL:  entry_o.kind = KIND_ACCEL;
      KIND_SENSOR: entry_o.kind = KIND_SENSOR;
      KIND_EVENT:  entry_o.kind = KIND_EVENT;
      default:     entry_o.kind = KIND_EVAL;
    endcase
  end

endmodule

// File: rtl/core/mgt_back.sv
module mgt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  mgt_pkg::qent_t    q_head_i,
  input  mgt_pkg::cfg_t     cfg_i,
  output mgt_pkg::bk_stat_t stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mgt_pkg::out_t     out_data_o
);
  import mgt_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00_0000_0000_0001,
    S_SQ   = 14'b00_0000_0000_0010,
    S_MAG  = 14'b00_0000_0000_0100,
    S_HPM  = 14'b00_0000_0000_1000,
    S_HPW  = 14'b00_0000_0001_0000,
    S_WALK = 14'b00_0000_0010_0000,
    S_DIV  = 14'b00_0000_0100_0000,
    S_RMS  = 14'b00_0000_1000_0000,
    S_BASE = 14'b00_0001_0000_0000,
    S_BUPD = 14'b00_0010_0000_0000,
    S_PCT  = 14'b00_0100_0000_0000,
    S_PST  = 14'b00_1000_0000_0000,
    S_PDIV = 14'b01_0000_0000_0000,
    S_OUT  = 14'b10_0000_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    W_MOTION = 2'd0,
    W_ACCEL  = 2'd1,
    W_SENSOR = 2'd2
  } walk_e;

  function automatic logic signed [49:0] trunc_div256(input logic signed [49:0] v);
    logic signed [49:0] adj;
    adj = v[49] ? (v + 50'sd255) : v;
    return adj >>> 8;
  endfunction

  // Control state.
  state_e              state_q, state_d;
  walk_e               sel_q, sel_d;
  logic [1:0]          sq_cnt_q, sq_cnt_d;
  logic                hp_acc_q, hp_acc_d;
  logic [15:0]         a_pin_q, a_pin_d, s_pin_q, s_pin_d;
  logic signed [31:0]  a_pout_q, a_pout_d, s_pout_q, s_pout_d;
  logic [MPOS_W-1:0]   mpos_q, mpos_d;
  logic [MFILL_W-1:0]  mfill_q, mfill_d;
  logic [BPOS_W-1:0]   apos_q, apos_d, spos_q, spos_d;
  logic [BFILL_W-1:0]  afill_q, afill_d, sfill_q, sfill_d;
  logic [15:0]         events_q, events_d;
  logic [7:0]          calm_q, calm_d;
  logic [15:0]         base_q, base_d, last_q, last_d;
  logic                rv_q, rv_d, pv_q, pv_d;
  logic                out_valid_q, out_valid_d;

  // Data path registers.
  logic signed [15:0]  ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic [31:0]         acc_q, acc_d;
  logic signed [49:0]  prod_q;
  logic [15:0]         hp_x_q, hp_x_d;
  logic [15:0]         energy_q, energy_d;
  logic [WALK_W-1:0]   cnt_q, cnt_d;
  logic                sign_q, sign_d;
  out_t                res_q, res_d, out_q, out_d;

  // Combinational helpers.
  logic signed [32:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [49:0]  mul_p;
  logic signed [15:0]  sq_v;
  logic [WALK_W-1:0]   walk_n;
  logic [15:0]         m_rdata, a_rdata, s_rdata;
  logic signed [15:0]  band_rd;
  logic signed [16:0]  diff;
  logic signed [31:0]  hp_pout;
  logic [15:0]         hp_pin;
  logic signed [49:0]  hp_q, hp_y, bdiv;
  logic [15:0]         hp_sat;
  logic [31:0]         qv, pmag;
  logic [15:0]         e1, base_n, rms;
  logic [7:0]          calm_n;
  logic signed [33:0]  pct_s;
  logic                m_we, a_we, s_we, load, q_pop;
  iter_req_t           it_req;
  iter_resp_t          it_resp;

  assign walk_n  = (sel_q == W_MOTION) ? WALK_W'(mfill_q) :
                   (sel_q == W_ACCEL)  ? WALK_W'(afill_q) : WALK_W'(sfill_q);
  assign band_rd = (sel_q == W_ACCEL) ? $signed(a_rdata) : $signed(s_rdata);
  assign diff    = $signed({1'b0, energy_q}) - $signed({1'b0, base_q});
  assign hp_pout = hp_acc_q ? a_pout_q : s_pout_q;
  assign hp_pin  = hp_acc_q ? a_pin_q : s_pin_q;
  assign sq_v    = (sq_cnt_q == 2'd0) ? ax_q : (sq_cnt_q == 2'd1) ? ay_q : az_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      S_SQ: begin
        mul_a = 33'(sq_v);
        mul_b = 17'(sq_v);
      end
      S_HPM: begin
        mul_a = 33'(hp_pout);
        mul_b = 17'sd243;
      end
      S_BASE: begin
        mul_a = 33'(diff);
        mul_b = $signed({8'b0, cfg_i.baseline_alpha_q8});
      end
      S_PCT: begin
        mul_a = 33'(diff);
        mul_b = 17'sd100;
      end
      default: begin
        if (sel_q == W_MOTION) begin
          mul_a = $signed({17'b0, m_rdata});
          mul_b = $signed({1'b0, m_rdata});
        end else begin
          mul_a = 33'(band_rd);
          mul_b = 17'(band_rd);
        end
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // High-pass filter step and baseline step, both rounding toward zero.
  assign hp_q   = trunc_div256(prod_q);
  assign hp_y   = $signed({34'b0, hp_x_q}) - $signed({34'b0, hp_pin}) + hp_q;
  assign hp_sat = (hp_y > 50'sd32767) ? 16'h7fff :
                  (hp_y < -50'sd32768) ? 16'h8000 : hp_y[15:0];
  assign bdiv   = trunc_div256(prod_q);
  assign pmag   = prod_q[49] ? 32'(-prod_q) : prod_q[31:0];
  assign qv     = (walk_n == '0) ? 32'd0 : it_resp.result;
  assign e1     = (sfill_q > BFILL_W'(BAND_DEPTH / 4)) ? energy_q + (qv[15:0] >> 2) : energy_q;
  assign base_n = (base_q == 16'd0) ? energy_q : base_q + bdiv[15:0];
  assign calm_n = (calm_q == 8'hff) ? calm_q : calm_q + 8'd1;
  assign rms    = it_resp.result[15:0];
  assign pct_s  = sign_q ? -$signed({2'b0, it_resp.result}) : $signed({2'b0, it_resp.result});
  assign load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer for one request at a time.
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    sq_cnt_d    = sq_cnt_q;
    hp_acc_d    = hp_acc_q;
    a_pin_d     = a_pin_q;
    a_pout_d    = a_pout_q;
    s_pin_d     = s_pin_q;
    s_pout_d    = s_pout_q;
    mpos_d      = mpos_q;
    mfill_d     = mfill_q;
    apos_d      = apos_q;
    afill_d     = afill_q;
    spos_d      = spos_q;
    sfill_d     = sfill_q;
    events_d    = events_q;
    calm_d      = calm_q;
    base_d      = base_q;
    last_d      = last_q;
    rv_d        = 1'b0;
    pv_d        = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    ax_d        = ax_q;
    ay_d        = ay_q;
    az_d        = az_q;
    acc_d       = acc_q;
    hp_x_d      = hp_x_q;
    energy_d    = energy_q;
    cnt_d       = cnt_q;
    sign_d      = sign_q;
    res_d       = res_q;
    out_d       = out_q;
    m_we        = 1'b0;
    a_we        = 1'b0;
    s_we        = 1'b0;
    q_pop       = 1'b0;
    it_req      = '0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop = 1'b1;
          case (q_head_i.kind)
            KIND_ACCEL: begin
              ax_d     = q_head_i.accel_x;
              ay_d     = q_head_i.accel_y;
              az_d     = q_head_i.accel_z;
              sq_cnt_d = 2'd0;
              acc_d    = '0;
              state_d  = S_SQ;
            end
            KIND_SENSOR: begin
              hp_x_d   = q_head_i.sensor_mv;
              hp_acc_d = 1'b0;
              state_d  = S_HPM;
            end
            KIND_EVENT: begin
              if (events_q != 16'hffff) begin
                events_d = events_q + 16'd1;
              end
            end
            default: begin
              sel_d   = W_MOTION;
              cnt_d   = '0;
              acc_d   = '0;
              state_d = S_WALK;
            end
          endcase
        end
      end
      // Sum of the three squares, one product per cycle.
      S_SQ: begin
        if (sq_cnt_q != 2'd0) begin
          acc_d = acc_q + prod_q[31:0];
        end
        if (sq_cnt_q == 2'd3) begin
          it_req.start = 1'b1;
          it_req.mode  = ITER_SQRT;
          it_req.a     = acc_q + prod_q[31:0];
          state_d      = S_MAG;
        end else begin
          sq_cnt_d = sq_cnt_q + 2'd1;
        end
      end
      S_MAG: begin
        if (it_resp.done) begin
          m_we     = 1'b1;
          mpos_d   = (mpos_q == MPOS_W'(MOTION_DEPTH - 1)) ? '0 : mpos_q + 1'b1;
          if (mfill_q != MFILL_W'(MOTION_DEPTH)) begin
            mfill_d = mfill_q + 1'b1;
          end
          hp_x_d   = rms;
          hp_acc_d = 1'b1;
          state_d  = S_HPM;
        end
      end
      S_HPM: begin
        state_d = S_HPW;
      end
      S_HPW: begin
        if (hp_acc_q) begin
          a_we     = 1'b1;
          a_pin_d  = hp_x_q;
          a_pout_d = hp_y[31:0];
          apos_d   = (apos_q == BPOS_W'(BAND_DEPTH - 1)) ? '0 : apos_q + 1'b1;
          if (afill_q != BFILL_W'(BAND_DEPTH)) begin
            afill_d = afill_q + 1'b1;
          end
        end else begin
          s_we     = 1'b1;
          s_pin_d  = hp_x_q;
          s_pout_d = hp_y[31:0];
          spos_d   = (spos_q == BPOS_W'(BAND_DEPTH - 1)) ? '0 : spos_q + 1'b1;
          if (sfill_q != BFILL_W'(BAND_DEPTH)) begin
            sfill_d = sfill_q + 1'b1;
          end
        end
        state_d = S_IDLE;
      end
      // Window walk: read, square, accumulate, one entry per cycle.
      S_WALK: begin
        if (cnt_q < walk_n) begin
          rv_d  = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        pv_d = rv_q;
        if (pv_q) begin
          acc_d = acc_q + prod_q[31:0];
        end
        if (!(cnt_q < walk_n) && !rv_q && !pv_q) begin
          it_req.start = (walk_n != '0);
          it_req.mode  = ITER_DIV;
          it_req.a     = acc_q;
          it_req.b     = 16'(walk_n);
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if ((walk_n == '0) || it_resp.done) begin
          case (sel_q)
            W_MOTION: begin
              it_req.start = 1'b1;
              it_req.mode  = ITER_SQRT;
              it_req.a     = qv;
              state_d      = S_RMS;
            end
            W_ACCEL: begin
              energy_d = qv[15:0];
              sel_d    = W_SENSOR;
              cnt_d    = '0;
              acc_d    = '0;
              state_d  = S_WALK;
            end
            default: begin
              energy_d = e1 + {events_q[12:0], 3'b000};
              state_d  = S_BASE;
            end
          endcase
        end
      end
      // Motion gate.
      S_RMS: begin
        if (it_resp.done) begin
          res_d.motion_rms  = rms;
          res_d.event_count = events_q;
          if (rms >= cfg_i.motion_rms_limit) begin
            res_d.moving      = 1'b1;
            res_d.mix_energy  = last_q;
            res_d.ema_energy  = base_q;
            res_d.trend       = TREND_UNKNOWN;
            res_d.trend_valid = 1'b0;
            calm_d            = '0;
            state_d           = S_OUT;
          end else begin
            sel_d   = W_ACCEL;
            cnt_d   = '0;
            acc_d   = '0;
            state_d = S_WALK;
          end
        end
      end
      S_BASE: begin
        last_d  = energy_q;
        state_d = S_BUPD;
      end
      S_BUPD: begin
        base_d            = base_n;
        calm_d            = calm_n;
        res_d.moving      = 1'b0;
        res_d.mix_energy  = energy_q;
        res_d.ema_energy  = base_n;
        res_d.trend       = TREND_UNKNOWN;
        res_d.trend_valid = 1'b0;
        if ((calm_n >= cfg_i.calm_windows_needed) && (base_n != 16'd0)) begin
          state_d = S_PCT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_PCT: begin
        state_d = S_PST;
      end
      S_PST: begin
        sign_d       = prod_q[49];
        it_req.start = 1'b1;
        it_req.mode  = ITER_DIV;
        it_req.a     = pmag;
        it_req.b     = base_q;
        state_d      = S_PDIV;
      end
      // Percentage change against the baseline.
      S_PDIV: begin
        if (it_resp.done) begin
          if (pct_s >= $signed({18'b0, cfg_i.rise_percent})) begin
            res_d.trend = TREND_RISING;
          end else if (pct_s <= -$signed({18'b0, cfg_i.fall_percent})) begin
            res_d.trend = TREND_FALLING;
          end else begin
            res_d.trend = TREND_STABLE;
          end
          res_d.trend_valid = 1'b1;
          state_d           = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          events_d    = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign stat_o = '{pop: q_pop, res_load: load};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= W_MOTION;
      sq_cnt_q    <= '0;
      hp_acc_q    <= 1'b0;
      a_pin_q     <= '0;
      a_pout_q    <= '0;
      s_pin_q     <= '0;
      s_pout_q    <= '0;
      mpos_q      <= '0;
      mfill_q     <= '0;
      apos_q      <= '0;
      afill_q     <= '0;
      spos_q      <= '0;
      sfill_q     <= '0;
      events_q    <= '0;
      calm_q      <= '0;
      base_q      <= '0;
      last_q      <= '0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      sq_cnt_q    <= sq_cnt_d;
      hp_acc_q    <= hp_acc_d;
      a_pin_q     <= a_pin_d;
      a_pout_q    <= a_pout_d;
      s_pin_q     <= s_pin_d;
      s_pout_q    <= s_pout_d;
      mpos_q      <= mpos_d;
      mfill_q     <= mfill_d;
      apos_q      <= apos_d;
      afill_q     <= afill_d;
      spos_q      <= spos_d;
      sfill_q     <= sfill_d;
      events_q    <= events_d;
      calm_q      <= calm_d;
      base_q      <= base_d;
      last_q      <= last_d;
      rv_q        <= rv_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    az_q     <= az_d;
    acc_q    <= acc_d;
    prod_q   <= mul_p;
    hp_x_q   <= hp_x_d;
    energy_q <= energy_d;
    cnt_q    <= cnt_d;
    sign_q   <= sign_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // Window stores.
  mgt_ram #(.Width(16), .Depth(MOTION_DEPTH)) u_motion_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (mpos_q),
    .wdata_i (rms),
    .raddr_i (cnt_q[MPOS_W-1:0]),
    .rdata_o (m_rdata)
  );

  mgt_ram #(.Width(16), .Depth(BAND_DEPTH)) u_accel_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (apos_q),
    .wdata_i (hp_sat),
    .raddr_i (cnt_q[BPOS_W-1:0]),
    .rdata_o (a_rdata)
  );

  mgt_ram #(.Width(16), .Depth(BAND_DEPTH)) u_sensor_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (spos_q),
    .wdata_i (hp_sat),
    .raddr_i (cnt_q[BPOS_W-1:0]),
    .rdata_o (s_rdata)
  );

  // Shared divider and square root.
  mgt_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (it_req),
    .resp_o (it_resp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
